// ===== src/drum_seq_pkg.sv =====
// shared types and constants of the drum step sequencer
package drum_seq_pkg;

  // field widths of the stream items
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TRACK_W    = 3;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned BPM_W      = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  // register reset values
  localparam logic [BPM_W-1:0]  TEMPO_RESET   = 9'd120;
  localparam logic [MASK_W-1:0] REVERSE_RESET = 8'd0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 2'd0,
    OP_START      = 2'd1,
    OP_STOP       = 2'd2,
    OP_CELL_WRITE = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPO   = 2'd0,
    CFG_REVERSE = 2'd1
  } cfg_idx_e;

  // input item payload, track in the low bits
  typedef struct packed {
    logic                cell_active;
    logic [STEP_W-1:0]   step_index;
    logic [TRACK_W-1:0]  track_index;
  } in_item_t;

  // result item payload, step in the low bits
  typedef struct packed {
    logic [MASK_W-1:0] reverse_flags;
    logic [MASK_W-1:0] trigger_mask;
    logic [STEP_W-1:0] current_step;
  } result_t;

  // grid cell write request
  typedef struct packed {
    logic               en;
    logic [TRACK_W-1:0] track_index;
    logic [STEP_W-1:0]  step_index;
    logic               cell_active;
  } grid_wr_t;

  // beat accumulator control
  typedef struct packed {
    logic clear;
    logic tick;
    logic first;
  } phase_ctl_t;

endpackage

// ===== src/drum_seq_grid.sv =====
// track-by-step trigger grid with one write and one read port
module drum_seq_grid #(
  parameter int unsigned TRACK_COUNT = 8,
  parameter int unsigned STEP_COUNT  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  drum_seq_pkg::grid_wr_t          wr_i,
  input  logic [$clog2(STEP_COUNT)-1:0]   rd_step_i,
  output logic [drum_seq_pkg::MASK_W-1:0] rd_mask_o
);

  localparam int unsigned CUR_W = $clog2(STEP_COUNT);
  // only steps and tracks reachable by the index fields are stored
  localparam int unsigned GRID_ROWS   = (STEP_COUNT < 16) ? STEP_COUNT : 16;
  localparam int unsigned GRID_TRACKS = (TRACK_COUNT < 8) ? TRACK_COUNT : 8;
  localparam int unsigned ROW_W = $clog2(GRID_ROWS);

  logic [GRID_TRACKS-1:0] grid_q [GRID_ROWS];

  logic                   wr_hit;
  logic [7:0]             sel_onehot;
  logic [GRID_TRACKS-1:0] bit_sel;
  logic [ROW_W-1:0]       wr_row;
  logic                   rd_hit;

  assign wr_hit = wr_i.en
                  && ({1'b0, wr_i.track_index} < 4'(GRID_TRACKS))
                  && ({1'b0, wr_i.step_index} < 5'(GRID_ROWS));
  assign sel_onehot = 8'd1 << wr_i.track_index;
  assign bit_sel    = GRID_TRACKS'(sel_onehot);
  assign wr_row     = wr_i.step_index[ROW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        grid_q[r] <= '0;
      end
    end else if (wr_hit) begin
      if (wr_i.cell_active) begin
        grid_q[wr_row] <= grid_q[wr_row] | bit_sel;
      end else begin
        grid_q[wr_row] <= grid_q[wr_row] & ~bit_sel;
      end
    end
  end

  // steps beyond the stored rows never hold a trigger
  assign rd_hit    = {1'b0, rd_step_i} < (CUR_W + 1)'(GRID_ROWS);
  assign rd_mask_o = rd_hit ? drum_seq_pkg::MASK_W'(grid_q[rd_step_i[ROW_W-1:0]]) : '0;

endmodule

// ===== src/drum_seq_tempo.sv =====
// tempo register and beat accumulator with step boundary detection
module drum_seq_tempo #(
  parameter int unsigned FRAMES_PER_TICK = 256,
  parameter int unsigned SAMPLE_HZ       = 44100,
  parameter int unsigned STEPS_PER_BEAT  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tempo_wr_i,
  input  logic [drum_seq_pkg::BPM_W-1:0] tempo_i,
  input  drum_seq_pkg::phase_ctl_t       ctl_i,
  output logic                           boundary_o
);

  localparam int unsigned THRESH  = (60 * SAMPLE_HZ) / STEPS_PER_BEAT;
  localparam int unsigned PHASE_W = $clog2(THRESH);
  localparam int unsigned INC_MAX = FRAMES_PER_TICK * ((1 << drum_seq_pkg::BPM_W) - 1);
  localparam int unsigned INC_W   = $clog2(INC_MAX + 1);
  localparam int unsigned SUM_W   = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;
  localparam int unsigned RED_W   = PHASE_W + 1;
  localparam int unsigned LO_W    = drum_seq_pkg::BPM_W - 1;
  localparam int unsigned LO_N    = 1 << LO_W;

  typedef logic [LO_N-1:0][PHASE_W-1:0] lo_tab_t;

  // increment modulo threshold for the low bpm bits
  function automatic lo_tab_t build_lo_tab();
    lo_tab_t t;
    for (int i = 0; i < LO_N; i++) begin
      t[i] = PHASE_W'((i * FRAMES_PER_TICK) % THRESH);
    end
    return t;
  endfunction

  localparam lo_tab_t          LO_TAB     = build_lo_tab();
  localparam logic [PHASE_W-1:0] HI_MOD   = PHASE_W'((LO_N * FRAMES_PER_TICK) % THRESH);
  localparam logic [INC_W-1:0]   INC_RST  =
    INC_W'(FRAMES_PER_TICK * int'(drum_seq_pkg::TEMPO_RESET));
  localparam logic [PHASE_W-1:0] IMOD_RST =
    PHASE_W'((FRAMES_PER_TICK * int'(drum_seq_pkg::TEMPO_RESET)) % THRESH);

  logic [INC_W-1:0]   inc_q, inc_d;
  logic [PHASE_W-1:0] inc_mod_q, inc_mod_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               over_q, over_d;   // true phase is past the threshold

  logic [RED_W-1:0]   mod_sum;
  logic [SUM_W-1:0]   full_sum;
  logic               full_ge;
  logic [RED_W-1:0]   red_sum;
  logic [PHASE_W-1:0] red_phase;

  // derived increment values, taken at the tempo write
  always_comb begin
    mod_sum   = RED_W'(LO_TAB[tempo_i[LO_W-1:0]])
              + (tempo_i[LO_W] ? RED_W'(HI_MOD) : '0);
    inc_d     = inc_q;
    inc_mod_d = inc_mod_q;
    if (tempo_wr_i) begin
      inc_d     = INC_W'(tempo_i) * INC_W'(FRAMES_PER_TICK);
      inc_mod_d = (mod_sum >= RED_W'(THRESH)) ? PHASE_W'(mod_sum - RED_W'(THRESH))
                                              : PHASE_W'(mod_sum);
    end
  end

  assign full_sum   = SUM_W'(phase_q) + SUM_W'(inc_q);
  assign full_ge    = full_sum >= SUM_W'(THRESH);
  assign red_sum    = RED_W'(phase_q) + RED_W'(inc_mod_q);
  assign red_phase  = (red_sum >= RED_W'(THRESH)) ? PHASE_W'(red_sum - RED_W'(THRESH))
                                                  : PHASE_W'(red_sum);
  assign boundary_o = over_q | full_ge;

  always_comb begin
    phase_d = phase_q;
    over_d  = over_q;
    if (ctl_i.clear) begin
      phase_d = '0;
      over_d  = 1'b0;
    end else if (ctl_i.tick) begin
      phase_d = red_phase;
      // a first beat tick keeps the boundary for the next tick
      over_d  = ctl_i.first ? (over_q | full_ge) : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q     <= INC_RST;
      inc_mod_q <= IMOD_RST;
      phase_q   <= '0;
      over_q    <= 1'b0;
    end else begin
      inc_q     <= inc_d;
      inc_mod_q <= inc_mod_d;
      phase_q   <= phase_d;
      over_q    <= over_d;
    end
  end

endmodule

// ===== src/drum_step_sequencer_core.sv =====
// top level of the drum step sequencer: input stage, control and result stage
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser op, tdata track/step/active
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser first beat, tdata step/masks
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
//  one item per cycle sustained while m_axis is not stalled: item is registered, then
//  decoded, applied to the grid and accumulator and its result registered in the next edge
//  from input accept to result valid an item passes the input register, then the result register
//  reset (rst_ni low, async) clears the grid, cursor, play state and accumulator
//  a stalled m_axis holds the result; the input stage then fills and
//  s_axis_tready drops; cfg is always ready
module drum_step_sequencer_core #(
  parameter int unsigned TRACK_COUNT     = 8,
  parameter int unsigned STEP_COUNT      = 16,
  parameter int unsigned FRAMES_PER_TICK = 256,
  parameter int unsigned SAMPLE_HZ       = 44100,
  parameter int unsigned STEPS_PER_BEAT  = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // input items
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [2:0] track_index, [6:3] step_index, [7] cell_active
  input  logic [drum_seq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] op
  input  logic [drum_seq_pkg::OP_W-1:0]           s_axis_tuser,
  // result items
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // [3:0] current_step, [11:4] trigger_mask, [19:12] reverse_flags, [23:20] zero
  output logic [drum_seq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] is_first_beat
  output logic                                    m_axis_tuser,
  // configuration writes
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [drum_seq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [drum_seq_pkg::BPM_W-1:0]          cfg_data_i
);

  localparam int unsigned CUR_W = $clog2(STEP_COUNT);
  localparam logic [CUR_W-1:0] LAST_STEP = CUR_W'(STEP_COUNT - 1);

  // input stage
  logic                   in_valid_q, in_valid_d;
  drum_seq_pkg::op_e      in_op_q;
  drum_seq_pkg::in_item_t in_item_q;
  logic                   s_accept;
  logic                   can_adv;
  logic                   fire;

  // play state
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic             running_q, running_d;
  logic             pending_q, pending_d;
  logic [drum_seq_pkg::MASK_W-1:0] reverse_q, reverse_d;

  // result stage
  logic                  out_valid_q, out_valid_d;
  drum_seq_pkg::result_t out_res_q, out_res_d;
  logic                  out_first_q, out_first_d;

  // datapath links
  logic [CUR_W-1:0]                 next_step;
  logic [CUR_W-1:0]                 rd_step;
  logic [drum_seq_pkg::MASK_W-1:0]  rd_mask;
  logic                             boundary;
  logic                             emit;
  logic                             emit_first;
  logic [CUR_W-1:0]                 emit_step;
  logic                             cfg_wr;
  drum_seq_pkg::grid_wr_t           grid_wr;
  drum_seq_pkg::phase_ctl_t         phase_ctl;

  // handshakes: the input stage moves on whenever the result slot is free or being taken
  assign can_adv       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && can_adv;
  assign s_axis_tready = !in_valid_q || can_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i && cfg_ready_o;

  assign in_valid_d = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= drum_seq_pkg::op_e'(s_axis_tuser);
      in_item_q <= drum_seq_pkg::in_item_t'(s_axis_tdata);
    end
  end

  // step after the cursor, wrapping at the last step
  assign next_step = (cursor_q == LAST_STEP) ? '0 : cursor_q + 1'b1;
  // a pending first beat reads the current step, otherwise the next one
  assign rd_step   = pending_q ? cursor_q : next_step;

  always_comb begin
    cursor_d    = cursor_q;
    running_d   = running_q;
    pending_d   = pending_q;
    emit        = 1'b0;
    emit_first  = 1'b0;
    emit_step   = cursor_q;
    grid_wr     = '0;
    phase_ctl   = '0;

    grid_wr.track_index = in_item_q.track_index;
    grid_wr.step_index  = in_item_q.step_index;
    grid_wr.cell_active = in_item_q.cell_active;

    if (fire) begin
      case (in_op_q)
        drum_seq_pkg::OP_START: begin
          cursor_d        = '0;
          running_d       = 1'b1;
          pending_d       = 1'b1;
          phase_ctl.clear = 1'b1;
        end
        drum_seq_pkg::OP_STOP: begin
          cursor_d        = '0;
          running_d       = 1'b0;
          pending_d       = 1'b0;
          phase_ctl.clear = 1'b1;
        end
        drum_seq_pkg::OP_CELL_WRITE: begin
          grid_wr.en = 1'b1;
        end
        drum_seq_pkg::OP_TICK: begin
          if (running_q) begin
            phase_ctl.tick  = 1'b1;
            phase_ctl.first = pending_q;
            if (pending_q) begin
              // first beat wins; any boundary waits for the next tick
              pending_d  = 1'b0;
              emit       = 1'b1;
              emit_first = 1'b1;
              emit_step  = cursor_q;
            end else if (boundary) begin
              cursor_d  = next_step;
              emit      = 1'b1;
              emit_step = next_step;
            end
          end
        end
        default: begin
          grid_wr.en = 1'b0;
        end
      endcase
    end
  end

  // reverse mask register
  always_comb begin
    reverse_d = reverse_q;
    if (cfg_wr && (cfg_index_i == drum_seq_pkg::CFG_REVERSE)) begin
      reverse_d = cfg_data_i[drum_seq_pkg::MASK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      running_q <= 1'b0;
      pending_q <= 1'b0;
      reverse_q <= drum_seq_pkg::REVERSE_RESET;
    end else begin
      cursor_q  <= cursor_d;
      running_q <= running_d;
      pending_q <= pending_d;
      reverse_q <= reverse_d;
    end
  end

  drum_seq_grid #(
    .TRACK_COUNT (TRACK_COUNT),
    .STEP_COUNT  (STEP_COUNT)
  ) u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grid_wr),
    .rd_step_i (rd_step),
    .rd_mask_o (rd_mask)
  );

  drum_seq_tempo #(
    .FRAMES_PER_TICK (FRAMES_PER_TICK),
    .SAMPLE_HZ       (SAMPLE_HZ),
    .STEPS_PER_BEAT  (STEPS_PER_BEAT)
  ) u_tempo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tempo_wr_i (cfg_wr && (cfg_index_i == drum_seq_pkg::CFG_TEMPO)),
    .tempo_i    (cfg_data_i),
    .ctl_i      (phase_ctl),
    .boundary_o (boundary)
  );

  // result stage: load on emit, drop once taken
  always_comb begin
    out_res_d   = out_res_q;
    out_first_d = out_first_q;
    if (fire) begin
      out_valid_d = emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    if (emit) begin
      out_res_d.current_step  = drum_seq_pkg::STEP_W'(emit_step);
      out_res_d.trigger_mask  = rd_mask;
      out_res_d.reverse_flags = rd_mask & reverse_q;
      out_first_d             = emit_first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q   <= out_res_d;
    out_first_q <= out_first_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drum_seq_pkg::OUT_TDATA_W'(out_res_q);
  assign m_axis_tuser  = out_first_q;

endmodule
